// ===== design/mexp_pkg.sv =====
// Package for the modular exponentiation unit.
// Widths, the prime modulus, the sequencer state type and multiplier port structs.
// No dependencies.
package mexp_pkg;

   localparam int IN_W      = 63;
   localparam int RES_W     = 30;
   localparam int BIT_CNT_W = $clog2(IN_W);
   localparam int MUL_CNT_W = $clog2(RES_W);

   localparam logic [RES_W+1:0] PRIME_MODULUS   = (RES_W+2)'(64'd1000000007);
   localparam logic [RES_W+1:0] PRIME_MODULUS_2 = (RES_W+2)'(64'd2000000014);

   typedef logic [IN_W-1:0]  operand_type;
   typedef logic [RES_W-1:0] residue_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_SQUARE,
      ST_MULT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        start;
      residue_type op_a;
      residue_type op_b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      residue_type product;
   } mul_stat_type;

endpackage

// ===== design/mexp_intf.sv =====
// Handshake interfaces for the request and response channels.
// Depends on mexp_pkg.
interface mexp_req_if;
   import mexp_pkg::*;
   logic        valid;
   logic        ready;
   operand_type base;
   operand_type exponent;
   modport source (output valid, base, exponent, input ready);
   modport sink   (input valid, base, exponent, output ready);
endinterface

interface mexp_rsp_if;
   import mexp_pkg::*;
   logic        valid;
   logic        ready;
   residue_type power_mod;
   modport source (output valid, power_mod, input ready);
   modport sink   (input valid, power_mod, output ready);
endinterface

// ===== design/mexp_mulmod.sv =====
// Bit-serial modular multiplier: op_a * op_b mod the prime, one bit of op_a per cycle.
// Depends on mexp_pkg.
module mexp_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  mexp_pkg::mul_req_type  mul_req,
   output mexp_pkg::mul_stat_type mul_stat
);
   import mexp_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   residue_type          a_sr_ff, a_sr_in;
   residue_type          b_ff, b_in;
   residue_type          r_ff, r_in;
   logic [RES_W+1:0]     sum;
   residue_type          r_step;

   // 2r + a_bit*b < 3P, so at most two subtractions of P
   always_comb begin
      sum = {r_ff, 1'b0} + (a_sr_ff[RES_W-1] ? {2'b00, b_ff} : '0);
      if (sum >= PRIME_MODULUS_2) begin
         r_step = RES_W'(sum - PRIME_MODULUS_2);
      end else if (sum >= PRIME_MODULUS) begin
         r_step = RES_W'(sum - PRIME_MODULUS);
      end else begin
         r_step = RES_W'(sum);
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_sr_in = a_sr_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (mul_req.start) begin
         run_in  = 1'b1;
         cnt_in  = MUL_CNT_W'(RES_W-1);
         a_sr_in = mul_req.op_a;
         b_in    = mul_req.op_b;
         r_in    = '0;
      end else if (run_ff) begin
         r_in    = r_step;
         a_sr_in = {a_sr_ff[RES_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      a_sr_ff <= a_sr_in;
      b_ff    <= b_in;
      r_ff    <= r_in;
   end

   assign mul_stat.done    = done_ff;
   assign mul_stat.product = r_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && run_ff))
      else $error("multiplier started while busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff) && !run_ff)
      else $error("done without a finished run");

   a_partial_reduced: assert property (@(posedge clock) disable iff (reset)
      (run_ff || done_ff) |-> ({2'b00, r_ff} < PRIME_MODULUS))
      else $error("partial product not reduced");

endmodule

// ===== design/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: base ** exponent mod 1000000007, square-and-multiply.
// Sequence, accept to result word: bit-serial reduction of the base mod P, a scan step per
// exponent bit down to the leading one, a square for each later bit plus a multiply by the
// reduced base when that bit is set, then the load of the output register. One word in flight; the next
// word is accepted as its result appears. Synchronous active-high reset returns the
// sequencer to idle and empties the output register. Depends on mexp_pkg, mexp_intf, mexp_mulmod.
module modular_exponentiation_unit (
   input logic       clock,
   input logic       reset,
   mexp_req_if.sink  req_ch,
   mexp_rsp_if.source rsp_ch
);
   import mexp_pkg::*;

   state_type            state_ff, state_in;
   operand_type          base_sr_ff, base_sr_in;
   operand_type          exp_ff, exp_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   residue_type          red_ff, red_in;
   residue_type          acc_ff, acc_in;
   logic                 started_ff, started_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   residue_type          rsp_data_ff, rsp_data_in;

   mul_req_type          mul_req;
   mul_stat_type         mul_stat;

   logic                 accept;
   logic                 cur_bit;
   logic                 last_bit;
   logic                 advance;
   logic                 load_rsp;
   logic [RES_W:0]       red_t;
   residue_type          red_next;

   mexp_mulmod u_mulmod (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_stat (mul_stat)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign cur_bit  = exp_ff[IN_W-1];
   assign last_bit = (cnt_ff == '0);
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
   assign advance  = ((state_ff == ST_SCAN) && !started_ff)
                  || ((state_ff == ST_SQUARE) && mul_stat.done && !cur_bit)
                  || ((state_ff == ST_MULT) && mul_stat.done);

   // base reduction, one bit per cycle: r = 2r + bit, minus P if needed
   always_comb begin
      red_t = {red_ff, base_sr_ff[IN_W-1]};
      if (red_t >= PRIME_MODULUS[RES_W:0]) begin
         red_next = RES_W'(red_t - PRIME_MODULUS[RES_W:0]);
      end else begin
         red_next = red_t[RES_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (last_bit) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (started_ff) state_in = ST_SQUARE;
            else if (last_bit) state_in = ST_FINISH;
         end
         ST_SQUARE: begin
            if (mul_stat.done) begin
               if (cur_bit) state_in = ST_MULT;
               else if (last_bit) state_in = ST_FINISH;
               else state_in = ST_SCAN;
            end
         end
         ST_MULT: begin
            if (mul_stat.done) state_in = last_bit ? ST_FINISH : ST_SCAN;
         end
         ST_FINISH: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready  = 1'b0;
      mul_req.start = 1'b0;
      mul_req.op_a  = acc_ff;
      mul_req.op_b  = acc_ff;
      unique case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_SCAN: mul_req.start = started_ff;
         ST_SQUARE: begin
            if (mul_stat.done && cur_bit) begin
               mul_req.start = 1'b1;
               mul_req.op_a  = mul_stat.product;
               mul_req.op_b  = red_ff;
            end
         end
         ST_REDUCE, ST_MULT, ST_FINISH: ;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      base_sr_in   = base_sr_ff;
      exp_in       = exp_ff;
      cnt_in       = cnt_ff;
      red_in       = red_ff;
      acc_in       = acc_ff;
      started_in   = started_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (accept) begin
         base_sr_in = req_ch.base;
         exp_in     = req_ch.exponent;
         cnt_in     = BIT_CNT_W'(IN_W-1);
         red_in     = '0;
         acc_in     = RES_W'(1);
         started_in = 1'b0;
      end
      if (state_ff == ST_REDUCE) begin
         red_in     = red_next;
         base_sr_in = {base_sr_ff[IN_W-2:0], 1'b0};
         cnt_in     = last_bit ? BIT_CNT_W'(IN_W-1) : cnt_ff - 1'b1;
      end
      if ((state_ff == ST_SCAN) && !started_ff && cur_bit) begin
         acc_in     = red_ff;
         started_in = 1'b1;
      end
      if (((state_ff == ST_SQUARE) || (state_ff == ST_MULT)) && mul_stat.done) begin
         acc_in = mul_stat.product;
      end
      if (advance) begin
         exp_in = {exp_ff[IN_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_sr_ff  <= base_sr_in;
      exp_ff      <= exp_in;
      cnt_ff      <= cnt_in;
      red_ff      <= red_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.power_mod = rsp_data_ff;

   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({2'b00, rsp_data_ff} < PRIME_MODULUS))
      else $error("result word not reduced");

   a_mul_only_started: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SQUARE) || (state_ff == ST_MULT)) |-> started_ff)
      else $error("multiply before leading exponent bit");

   a_load_keeps_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result word overwritten");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("output not empty after reset");

endmodule
